### src/ffpc_pkg.sv
// ----------------------------------------------------------------------------
// ffpc_pkg: shared types and constants of the frame field parser
// Word types of the input and result channels, check codes and widths.
// ----------------------------------------------------------------------------
package ffpc_pkg;

  localparam int unsigned POS_W = 9;
  localparam logic [3:0] LENGTH_UNIT_RESET = 4'd5;
  localparam logic [15:0] SUM_GOOD = 16'hFFFF;

  typedef enum logic [1:0] {
    CHK_PARITY = 2'd0,
    CHK_CRC    = 2'd1,
    CHK_SUM    = 2'd2,
    CHK_XOR    = 2'd3
  } check_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic [2:0] language;
    logic [7:0] message_length;
    logic [7:0] dest_id;
    logic [7:0] source_id;
    logic [1:0] cipher;
    logic [1:0] check_type;
    logic       parity_odd;
    logic [1:0] line_code;
    logic       medium_type;
    logic [1:0] medium_res;
    logic       frame_error;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

### src/ffpc_in_if.sv
// ----------------------------------------------------------------------------
// ffpc_in_if: input byte channel
// Valid/ready channel carrying one frame byte and the frame start flag.
// ----------------------------------------------------------------------------
interface ffpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

### src/ffpc_out_if.sv
// ----------------------------------------------------------------------------
// ffpc_out_if: result channel
// Valid/ready channel carrying the decoded fields of one frame.
// ----------------------------------------------------------------------------
interface ffpc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] language;
  logic [7:0] message_length;
  logic [7:0] dest_id;
  logic [7:0] source_id;
  logic [1:0] cipher;
  logic [1:0] check_type;
  logic       parity_odd;
  logic [1:0] line_code;
  logic       medium_type;
  logic [1:0] medium_res;
  logic       frame_error;

  modport source (
    output valid, output language, output message_length, output dest_id,
    output source_id, output cipher, output check_type, output parity_odd,
    output line_code, output medium_type, output medium_res, output frame_error,
    input ready
  );
  modport sink (
    input valid, input language, input message_length, input dest_id,
    input source_id, input cipher, input check_type, input parity_odd,
    input line_code, input medium_type, input medium_res, input frame_error,
    output ready
  );
endinterface

### src/ffpc_in_stage.sv
// ----------------------------------------------------------------------------
// ffpc_in_stage: input register
// Holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module ffpc_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  ffpc_in_if.sink             in_i,
  input  logic                advance_i,
  output logic                valid_o,
  output ffpc_pkg::in_word_t  word_o
);
  import ffpc_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q;
  logic     take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q.data_byte   <= in_i.data_byte;
      word_q.frame_start <= in_i.frame_start;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
endmodule

### src/ffpc_core.sv
// ----------------------------------------------------------------------------
// ffpc_core: frame state and field decode
// Tracks the byte position, captures the header fields, runs the parity,
// XOR and ones-complement accumulators and forms the result at the last byte.
// ----------------------------------------------------------------------------
module ffpc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3:0]           length_unit_i,
  input  ffpc_pkg::stage_ctl_t ctl_i,
  input  ffpc_pkg::in_word_t   word_i,
  output logic                 last_o,
  output ffpc_pkg::out_word_t  result_o
);
  import ffpc_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       mlen_q, mlen_d;
  logic [2:0]       lang_q, lang_d;
  logic [7:0]       dest_q, dest_d;
  logic [7:0]       src_q, src_d;
  logic [7:0]       ck_q, ck_d;
  logic             par_q, par_d;
  logic [7:0]       xor_q, xor_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       hold_q, hold_d;

  logic             hdr;
  logic [8:0]       prod;
  logic [POS_W-1:0] m_ext;
  logic [POS_W-1:0] extra;
  logic [1:0]       ctype;
  logic             last;
  logic [15:0]      word;
  logic [16:0]      sum_t;
  logic [15:0]      sum_wrap;
  logic             podd;
  logic             err;
  logic [7:0]       b;
  logic             fire;

  assign b     = word_i.data_byte;
  assign fire  = ctl_i.valid && ctl_i.advance;
  assign hdr   = word_i.frame_start || (pos_q == '0);
  assign prod  = 9'(b[4:0]) * 9'(length_unit_i);
  assign m_ext = POS_W'(mlen_q);

  always_comb begin
    dest_d = dest_q;
    src_d  = src_q;
    ck_d   = ck_q;
    if (pos_q == m_ext + POS_W'(1)) begin
      dest_d = b;
    end else if (pos_q == m_ext + POS_W'(2)) begin
      src_d = b;
    end else if (pos_q == m_ext + POS_W'(3)) begin
      ck_d = b;
    end
  end

  assign ctype = ck_d[5:4];

  always_comb begin
    case (check_e'(ctype))
      CHK_PARITY: extra = POS_W'(0);
      CHK_SUM:    extra = POS_W'(2);
      default:    extra = POS_W'(1);
    endcase
  end

  assign last = !hdr && (pos_q == m_ext + POS_W'(4) + extra);

  assign par_d    = par_q ^ (^b);
  assign xor_d    = xor_q ^ b;
  assign word     = pos_q[0] ? {b, 8'h00} : {hold_q, b};
  assign sum_t    = {1'b0, sum_q} + {1'b0, word};
  assign sum_wrap = sum_t[15:0] + 16'(sum_t[16]);
  assign sum_d    = (!pos_q[0] || last) ? sum_wrap : sum_q;
  assign hold_d   = pos_q[0] ? b : hold_q;
  assign pos_d    = last ? '0 : pos_q + POS_W'(1);
  assign mlen_d   = prod[8] ? 8'hFF : prod[7:0];
  assign lang_d   = b[7:5];
  assign podd     = (check_e'(ctype) == CHK_PARITY) ? ck_d[1] : 1'b0;

  always_comb begin
    case (check_e'(ctype))
      CHK_PARITY: err = podd ? !par_d : par_d;
      CHK_CRC:    err = 1'b0;
      CHK_SUM:    err = (sum_d != SUM_GOOD);
      CHK_XOR:    err = (xor_d != 8'h00);
      default:    err = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      mlen_q <= '0;
      lang_q <= '0;
      dest_q <= '0;
      src_q  <= '0;
      ck_q   <= '0;
      par_q  <= 1'b0;
      xor_q  <= '0;
      sum_q  <= '0;
      hold_q <= '0;
    end else if (fire) begin
      if (hdr) begin
        pos_q  <= POS_W'(1);
        mlen_q <= mlen_d;
        lang_q <= lang_d;
        dest_q <= '0;
        src_q  <= '0;
        ck_q   <= '0;
        par_q  <= ^b;
        xor_q  <= b;
        sum_q  <= '0;
        hold_q <= '0;
      end else begin
        pos_q  <= pos_d;
        dest_q <= dest_d;
        src_q  <= src_d;
        ck_q   <= ck_d;
        par_q  <= par_d;
        xor_q  <= xor_d;
        sum_q  <= sum_d;
        hold_q <= hold_d;
      end
    end
  end

  assign last_o = last;

  always_comb begin
    result_o.language       = lang_q;
    result_o.message_length = mlen_q;
    result_o.dest_id        = dest_q;
    result_o.source_id      = src_q;
    result_o.cipher         = ck_d[7:6];
    result_o.check_type     = ctype;
    result_o.parity_odd     = podd;
    result_o.line_code      = b[7:6];
    result_o.medium_type    = b[5];
    result_o.medium_res     = b[4:3];
    result_o.frame_error    = err;
  end
endmodule

### src/ffpc_out_stage.sv
// ----------------------------------------------------------------------------
// ffpc_out_stage: result register
// Holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module ffpc_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ffpc_pkg::out_word_t result_i,
  output logic                busy_o,
  ffpc_out_if.source          out_o
);
  import ffpc_pkg::*;

  logic      valid_q, valid_d;
  out_word_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign busy_o = valid_q && !out_o.ready;

  assign out_o.valid          = valid_q;
  assign out_o.language       = res_q.language;
  assign out_o.message_length = res_q.message_length;
  assign out_o.dest_id        = res_q.dest_id;
  assign out_o.source_id      = res_q.source_id;
  assign out_o.cipher         = res_q.cipher;
  assign out_o.check_type     = res_q.check_type;
  assign out_o.parity_odd     = res_q.parity_odd;
  assign out_o.line_code      = res_q.line_code;
  assign out_o.medium_type    = res_q.medium_type;
  assign out_o.medium_res     = res_q.medium_res;
  assign out_o.frame_error    = res_q.frame_error;
endmodule

### src/frame_field_parse_and_check.sv
// ----------------------------------------------------------------------------
// frame_field_parse_and_check: byte-serial frame parser and checker
// Frame bytes enter on in_i, one word per byte. A byte with frame_start set,
// or the first byte after reset or after a finished frame, is the header.
// When the link byte closing a frame is consumed, one word with the decoded
// fields and the error flag of the selected check is offered on out_o; no
// other byte yields a word.
// Throughput is one byte per cycle unless a closing byte waits for the result
// register. An accepted byte is parsed from the input register, and a closing
// byte, when consumed, loads the result register, which offers its word on
// out_o. The length unit is written through length_unit_we_i and
// length_unit_i; the user must write it only while no frame byte is in
// flight, which the block itself does not enforce. It resets to 5.
// Reset empties both registers and returns the parser to expecting a header.
// When the receiver stalls, the result register holds its word; bytes that
// yield no result keep flowing, and a closing byte waits in the input
// register until the result register is free.
// ----------------------------------------------------------------------------
module frame_field_parse_and_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       length_unit_we_i,
  input  logic [3:0] length_unit_i,
  ffpc_in_if.sink    in_i,
  ffpc_out_if.source out_o
);
  import ffpc_pkg::*;

  logic       [3:0] unit_q;
  stage_ctl_t       ctl;
  in_word_t         word;
  out_word_t        result;
  logic             last;
  logic             busy;
  logic             load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= LENGTH_UNIT_RESET;
    end else if (length_unit_we_i) begin
      unit_q <= length_unit_i;
    end
  end

  assign ctl.advance = ctl.valid && (!last || !busy);
  assign load        = ctl.advance && last;

  ffpc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (ctl.advance),
    .valid_o   (ctl.valid),
    .word_o    (word)
  );

  ffpc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .length_unit_i (unit_q),
    .ctl_i         (ctl),
    .word_i        (word),
    .last_o        (last),
    .result_o      (result)
  );

  ffpc_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .result_i (result),
    .busy_o   (busy),
    .out_o    (out_o)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !load)
    else $error("result register overwritten while stalled");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_o.valid)
    else $error("loaded result not offered");

  a_advance_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.advance |-> ctl.valid)
    else $error("parser advanced on an empty input register");
`endif
endmodule
